// ----- sv/gnms_pkg.sv -----
// ----------------------------------------------------------------------------
// gnms_pkg
// Shared types, sizes and constants of the gradient non-maximum suppression
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package gnms_pkg;

    localparam int IMAGE_WIDTH    = 256;
    localparam int IMAGE_HEIGHT   = 256;
    localparam int MAGNITUDE_BITS = 24;

    localparam int COL_W    = $clog2(IMAGE_WIDTH);
    localparam int ROW_W    = $clog2(IMAGE_HEIGHT);
    localparam int MAG_IN_W = 24;
    localparam int GRAD_W   = 24;
    localparam int POS_W    = 8;

    // Sector thresholds tan(22.5 deg) and tan(67.5 deg) in unsigned Q16
    localparam int LOW_W  = 15;
    localparam int HIGH_W = 18;
    localparam logic [LOW_W-1:0]  SLOPE_LOW_Q16  = 15'd27145;
    localparam logic [HIGH_W-1:0] SLOPE_HIGH_Q16 = 18'd158217;

    typedef logic [MAGNITUDE_BITS-1:0] mag_t;
    typedef logic [COL_W-1:0]          col_t;
    typedef logic [ROW_W-1:0]          row_t;

    typedef enum logic [1:0] {
        SEC_VERT      = 2'd0,  // neighbors above and below
        SEC_DIAG_DOWN = 2'd1,  // up-left and down-right
        SEC_DIAG_UP   = 2'd2,  // up-right and down-left
        SEC_HORIZ     = 2'd3   // left and right
    } sector_t;

    typedef struct packed {
        logic    en;
        col_t    col;
        sector_t sector;
    } sec_wr_t;

    typedef struct packed {
        logic             is_peak;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] column;
        logic             last_of_run;
    } result_t;

endpackage

`default_nettype wire

// ----- sv/gnms_if.sv -----
// ----------------------------------------------------------------------------
// gnms_if
// Valid/ready channels of the block: gradient pixels in, decisions out.
// ----------------------------------------------------------------------------
`default_nettype none

interface gnms_pixel_if;
    import gnms_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [MAG_IN_W-1:0]      magnitude;
    logic signed [GRAD_W-1:0] gradient_x;
    logic signed [GRAD_W-1:0] gradient_y;

    modport source (output valid, magnitude, gradient_x, gradient_y, input ready);
    modport sink   (input valid, magnitude, gradient_x, gradient_y, output ready);
endinterface

interface gnms_result_if;
    import gnms_pkg::*;

    logic             valid;
    logic             ready;
    logic             is_peak;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] column;
    logic             last_of_run;

    modport source (output valid, is_peak, row, column, last_of_run, input ready);
    modport sink   (input valid, is_peak, row, column, last_of_run, output ready);
endinterface

`default_nettype wire

// ----- sv/gnms_sector.sv -----
// ----------------------------------------------------------------------------
// gnms_sector
// Gradient direction sector by cross-multiplication: multiply stage, then
// compare stage feeding the sector line write port.
// ----------------------------------------------------------------------------
`default_nettype none

module gnms_sector (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              fire,
    input  wire logic signed [gnms_pkg::GRAD_W-1:0] gradient_x,
    input  wire logic signed [gnms_pkg::GRAD_W-1:0] gradient_y,
    input  wire gnms_pkg::col_t                     col,
    output gnms_pkg::sec_wr_t                       sec_wr
);
    import gnms_pkg::*;

    localparam int AX_W   = GRAD_W;          // |gx| fits unsigned
    localparam int AY_W   = GRAD_W + 1;      // sign-adjusted gy
    localparam int LO_W   = LOW_W + AX_W;
    localparam int HI_W   = HIGH_W + AX_W;
    localparam int CMP_W  = HI_W + 2;

    logic [AX_W-1:0]        ax;
    logic signed [AY_W-1:0] ay;

    logic                   valid_reg;
    col_t                   col_reg;
    logic                   zero_x_reg;
    logic                   zero_y_reg;
    logic signed [AY_W-1:0] ay_reg;
    logic [LO_W-1:0]        lo_reg;
    logic [HI_W-1:0]        hi_reg;

    logic signed [CMP_W-1:0] yq;
    logic signed [CMP_W-1:0] lo_s;
    logic signed [CMP_W-1:0] hi_s;
    sector_t                 sector;

    always_comb
    begin
        if (gradient_x[GRAD_W-1])
        begin
            ax = AX_W'(-gradient_x);
            ay = -AY_W'(gradient_y);
        end
        else
        begin
            ax = AX_W'(gradient_x);
            ay = AY_W'(gradient_y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            col_reg    <= col;
            zero_x_reg <= (gradient_x == '0);
            zero_y_reg <= (gradient_y == '0);
            ay_reg     <= ay;
            lo_reg     <= LO_W'(SLOPE_LOW_Q16) * LO_W'(ax);
            hi_reg     <= HI_W'(SLOPE_HIGH_Q16) * HI_W'(ax);
        end
    end

    always_comb
    begin
        yq   = CMP_W'(ay_reg) <<< 16;
        lo_s = $signed(CMP_W'(lo_reg));
        hi_s = $signed(CMP_W'(hi_reg));
        priority if (zero_x_reg)
            sector = zero_y_reg ? SEC_VERT : SEC_HORIZ;
        else if (yq > -lo_s && yq <= lo_s)
            sector = SEC_VERT;
        else if (yq > lo_s && yq <= hi_s)
            sector = SEC_DIAG_DOWN;
        else if (yq > -hi_s && yq <= -lo_s)
            sector = SEC_DIAG_UP;
        else
            sector = SEC_HORIZ;
    end

    assign sec_wr.en     = valid_reg;
    assign sec_wr.col    = col_reg;
    assign sec_wr.sector = sector;

    // exact zero x must always land on the vertical or horizontal sector
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && zero_x_reg |-> sector == SEC_VERT || sector == SEC_HORIZ)
        else $error("zero x gradient gave a diagonal sector");
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> valid_reg && col_reg == $past(col))
        else $error("sector stage lost a column");
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !zero_x_reg && ay_reg == '0 |-> sector == SEC_VERT)
        else $error("flat gradient not vertical sector");

endmodule

`default_nettype wire

// ----- sv/gnms_linebuf.sv -----
// ----------------------------------------------------------------------------
// gnms_linebuf
// Two magnitude line memories and the sector line memory, one registered
// read and one write per cycle each.
// ----------------------------------------------------------------------------
`default_nettype none

module gnms_linebuf (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire gnms_pkg::col_t    rd_col,
    output gnms_pkg::mag_t         rd_above,
    output gnms_pkg::mag_t         rd_two,
    output gnms_pkg::sector_t      rd_sector,
    input  wire logic              wr_en,
    input  wire gnms_pkg::col_t    wr_col,
    input  wire gnms_pkg::mag_t    wr_above,
    input  wire gnms_pkg::mag_t    wr_two,
    input  wire gnms_pkg::sec_wr_t sec_wr
);
    import gnms_pkg::*;

    mag_t    above_mem [IMAGE_WIDTH];
    mag_t    two_mem   [IMAGE_WIDTH];
    sector_t sec_mem   [IMAGE_WIDTH];

    mag_t    rd_above_reg;
    mag_t    rd_two_reg;
    sector_t rd_sector_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            above_mem[wr_col] <= wr_above;
        end
        if (rd_en)
        begin
            rd_above_reg <= above_mem[rd_col];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            two_mem[wr_col] <= wr_two;
        end
        if (rd_en)
        begin
            rd_two_reg <= two_mem[rd_col];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sec_wr.en)
        begin
            sec_mem[sec_wr.col] <= sec_wr.sector;
        end
        if (rd_en)
        begin
            rd_sector_reg <= sec_mem[rd_col];
        end
    end

    assign rd_above  = rd_above_reg;
    assign rd_two    = rd_two_reg;
    assign rd_sector = rd_sector_reg;

endmodule

`default_nettype wire

// ----- sv/gnms_out_buf.sv -----
// ----------------------------------------------------------------------------
// gnms_out_buf
// Result register plus one pending slot for the extra end-of-row result.
// ----------------------------------------------------------------------------
`default_nettype none

module gnms_out_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire gnms_pkg::result_t first,
    input  wire gnms_pkg::result_t second,
    input  wire logic              second_valid,
    output logic                   free,
    gnms_result_if.source          result_out
);
    import gnms_pkg::*;

    logic    out_valid_reg;
    logic    pend_valid_reg;
    result_t out_reg;
    result_t pend_reg;

    assign free = !out_valid_reg || (result_out.ready && !pend_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg  <= 1'b1;
            pend_valid_reg <= second_valid;
        end
        else if (out_valid_reg && result_out.ready)
        begin
            out_valid_reg  <= pend_valid_reg;
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg  <= first;
            pend_reg <= second;
        end
        else if (out_valid_reg && result_out.ready && pend_valid_reg)
        begin
            out_reg <= pend_reg;
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.is_peak     = out_reg.is_peak;
    assign result_out.row         = out_reg.row;
    assign result_out.column      = out_reg.column;
    assign result_out.last_of_run = out_reg.last_of_run;

    assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("pending result without a shown result");
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> !out_reg.last_of_run)
        else $error("first of a result pair flagged last");
    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("result buffer overrun");

endmodule

`default_nettype wire

// ----- sv/gradient_non_maximum_suppression.sv -----
// ----------------------------------------------------------------------------
// gradient_non_maximum_suppression
// Raster-stream non-maximum suppression of gradient pixels: line memories,
// a 3x3 magnitude window and a per-pixel direction sector.
// ----------------------------------------------------------------------------
//
//  channel     dir  handshake     payload
//  pixel_in    in   valid/ready   magnitude, gradient_x, gradient_y
//  result_out  out  valid/ready   is_peak, row, column, last_of_run
//
//  One pixel per clock when result_out keeps ready high; pixels of row 0 and
//  column 0 give no transaction, the last column of each row gives two.
//  The second of those holds pixel_in.ready low while it waits in the
//  pending slot of the result buffer. A decision is formed in the input
//  stage and registered in the result buffer. Reset clears position, window,
//  sector hold and handshake state; line memories need no clearing since
//  unwritten entries only feed border pixels. A stall on result_out backs
//  up into pixel_in.ready through the input stage.
//
`default_nettype none

module gradient_non_maximum_suppression (
    input  wire logic     clk,
    input  wire logic     rst_n,
    gnms_pixel_if.sink    pixel_in,
    gnms_result_if.source result_out
);
    import gnms_pkg::*;

    // ------------------------------------------------------------------
    // Position counters of the incoming pixel
    // ------------------------------------------------------------------
    col_t col_reg;
    row_t row_reg;

    // ------------------------------------------------------------------
    // Input stage: one pixel, its position and the line memory reads
    // ------------------------------------------------------------------
    logic                     s1_valid_reg;
    mag_t                     s1_mag_reg;
    logic signed [GRAD_W-1:0] s1_gx_reg;
    logic signed [GRAD_W-1:0] s1_gy_reg;
    col_t                     s1_col_reg;
    row_t                     s1_row_reg;

    logic    accept;
    logic    s1_fire;
    logic    out_free;

    mag_t    rd_above;
    mag_t    rd_two;
    sector_t rd_sector;
    sec_wr_t sec_wr;

    // Window columns, index 0 = top row. Column 2 is the newest.
    mag_t    win_col1_reg [3];
    mag_t    win_col2_reg [3];
    sector_t sector_hold_reg;

    mag_t    center;
    mag_t    n1;
    mag_t    n2;
    logic    emit;
    logic    two_results;
    logic    peak;
    result_t res_first;
    result_t res_second;

    assign accept         = pixel_in.valid && pixel_in.ready;
    assign s1_fire        = s1_valid_reg && out_free;
    assign pixel_in.ready = !s1_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (col_reg == COL_W'(IMAGE_WIDTH - 1))
            begin
                col_reg <= '0;
                row_reg <= (row_reg == ROW_W'(IMAGE_HEIGHT - 1)) ? '0
                                                                : row_reg + ROW_W'(1);
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mag_reg <= MAGNITUDE_BITS'(pixel_in.magnitude);
            s1_gx_reg  <= pixel_in.gradient_x;
            s1_gy_reg  <= pixel_in.gradient_y;
            s1_col_reg <= col_reg;
            s1_row_reg <= row_reg;
        end
    end

    // Reads issue on accept, writes retire on s1_fire; the two always hit
    // different columns since a column comes back only a full row later.
    gnms_linebuf u_linebuf (
        .clk       (clk),
        .rd_en     (accept),
        .rd_col    (col_reg),
        .rd_above  (rd_above),
        .rd_two    (rd_two),
        .rd_sector (rd_sector),
        .wr_en     (s1_fire),
        .wr_col    (s1_col_reg),
        .wr_above  (s1_mag_reg),
        .wr_two    (rd_above),
        .sec_wr    (sec_wr)
    );

    gnms_sector u_sector (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (s1_fire),
        .gradient_x (s1_gx_reg),
        .gradient_y (s1_gy_reg),
        .col        (s1_col_reg),
        .sec_wr     (sec_wr)
    );

    // ------------------------------------------------------------------
    // Window shift and sector hold
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_col1_reg[i] <= '0;
                win_col2_reg[i] <= '0;
            end
            sector_hold_reg <= SEC_VERT;
        end
        else if (s1_fire)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_col1_reg[i] <= win_col2_reg[i];
            end
            win_col2_reg[0] <= rd_two;
            win_col2_reg[1] <= rd_above;
            win_col2_reg[2] <= s1_mag_reg;
            sector_hold_reg <= rd_sector;
        end
    end

    // ------------------------------------------------------------------
    // Decision on the pixel one row up and one column left. After the
    // shift, old column 2 is the center column, old column 1 is left and
    // the freshly read data is right.
    // ------------------------------------------------------------------
    always_comb
    begin
        center = win_col2_reg[1];
        unique case (sector_hold_reg)
            SEC_VERT:
            begin
                n1 = win_col2_reg[0];
                n2 = win_col2_reg[2];
            end
            SEC_DIAG_DOWN:
            begin
                n1 = win_col1_reg[0];
                n2 = s1_mag_reg;
            end
            SEC_DIAG_UP:
            begin
                n1 = rd_two;
                n2 = win_col1_reg[2];
            end
            SEC_HORIZ:
            begin
                n1 = rd_above;
                n2 = win_col1_reg[1];
            end
        endcase
    end

    // Border pixels (first row, first column, last column) never peak; the
    // last column is decided by the extra result with is_peak forced low.
    assign emit        = (s1_row_reg != '0) && (s1_col_reg != '0);
    assign two_results = (s1_col_reg == COL_W'(IMAGE_WIDTH - 1));
    assign peak        = (s1_row_reg >= ROW_W'(2)) && (s1_col_reg >= COL_W'(2)) &&
                         (center > n1) && (center > n2);

    always_comb
    begin
        res_first.is_peak      = peak;
        res_first.row          = POS_W'(s1_row_reg - ROW_W'(1));
        res_first.column       = POS_W'(s1_col_reg - COL_W'(1));
        res_first.last_of_run  = !two_results;
        res_second.is_peak     = 1'b0;
        res_second.row         = POS_W'(s1_row_reg - ROW_W'(1));
        res_second.column      = POS_W'(s1_col_reg);
        res_second.last_of_run = 1'b1;
    end

    gnms_out_buf u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (s1_fire && emit),
        .first        (res_first),
        .second       (res_second),
        .second_valid (two_results),
        .free         (out_free),
        .result_out   (result_out)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !s1_valid_reg || s1_fire)
        else $error("input stage overwritten before it retired");
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && emit && two_results |=> result_out.valid && !out_free)
        else $error("row-end result pair not held");
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && emit |=> result_out.valid)
        else $error("decision not presented");
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && (s1_row_reg == '0 || s1_col_reg < COL_W'(2)) |-> !peak)
        else $error("border pixel flagged as peak");

endmodule

`default_nettype wire

// ----- verif/gnms_checker.sv -----
// ----------------------------------------------------------------------------
// gnms_checker
// Watches both channels of the suppression block, predicts every decision
// transaction from the accepted pixel stream and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gnms_checker (
    input  wire logic   clk,
    input  wire logic   rst_n,
    gnms_pixel_if       pixels,
    gnms_result_if      decisions,
    output int unsigned fail_count,
    output int unsigned outstanding,
    output int unsigned pixels_seen,
    output int unsigned decisions_seen,
    output int unsigned peaks_seen
);
    import gnms_pkg::*;

    // tan(22.5 deg) and tan(67.5 deg) in Q16
    localparam longint TAN_LOW_Q16  = 27145;
    localparam longint TAN_HIGH_Q16 = 158217;
    localparam int     PRINT_LIMIT  = 40;

    mag_t        line_above      [IMAGE_WIDTH];
    mag_t        line_two_above  [IMAGE_WIDTH];
    sector_t     sector_row      [IMAGE_WIDTH];
    sector_t     held_sector;
    mag_t        window          [3][3];
    int unsigned pos_row;
    int unsigned pos_col;
    result_t     expected_decisions [$];

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_LIMIT)
            $display("[%0t] ERROR: %s", $time, msg);
        fail_count++;
    endtask

    // y/x compared against the thresholds by cross-multiplication
    function automatic sector_t gradient_sector(input logic signed [GRAD_W-1:0] gx,
                                                input logic signed [GRAD_W-1:0] gy);
        longint ax, ay, yq, lo, hi;
        if (gx == 0)
            return (gy == 0) ? SEC_VERT : SEC_HORIZ;
        ax = (gx < 0) ? -longint'(gx) : longint'(gx);
        ay = (gx < 0) ? -longint'(gy) : longint'(gy);
        yq = ay * 65536;
        lo = TAN_LOW_Q16 * ax;
        hi = TAN_HIGH_Q16 * ax;
        if (yq > -lo && yq <= lo)
            return SEC_VERT;
        if (yq > lo && yq <= hi)
            return SEC_DIAG_DOWN;
        if (yq > -hi && yq <= -lo)
            return SEC_DIAG_UP;
        return SEC_HORIZ;
    endfunction

    task automatic predict_decisions(input logic [MAG_IN_W-1:0]      mag,
                                     input logic signed [GRAD_W-1:0] gx,
                                     input logic signed [GRAD_W-1:0] gy);
        mag_t        fresh, center, n1, n2;
        sector_t     fresh_sec, due_sec;
        int unsigned r, c;
        int          i;
        result_t     d;
        fresh     = mag[MAGNITUDE_BITS-1:0];
        fresh_sec = gradient_sector(gx, gy);
        r = pos_row;
        c = pos_col;

        for (i = 0; i < 3; i++)
        begin
            window[i][0] = window[i][1];
            window[i][1] = window[i][2];
        end
        window[0][2]      = line_two_above[c];
        window[1][2]      = line_above[c];
        window[2][2]      = fresh;
        line_two_above[c] = line_above[c];
        line_above[c]     = fresh;

        // decision is for (r-1, c-1); its sector was stored one row earlier
        due_sec       = held_sector;
        held_sector   = sector_row[c];
        sector_row[c] = fresh_sec;

        if (r >= 1 && c >= 1)
        begin
            case (due_sec)
                SEC_VERT:      begin n1 = window[0][1]; n2 = window[2][1]; end
                SEC_DIAG_DOWN: begin n1 = window[0][0]; n2 = window[2][2]; end
                SEC_DIAG_UP:   begin n1 = window[0][2]; n2 = window[2][0]; end
                default:       begin n1 = window[1][2]; n2 = window[1][0]; end
            endcase
            center        = window[1][1];
            d.is_peak     = (r - 1 >= 1) && (c - 1 >= 1) && (c - 1 <= IMAGE_WIDTH - 2) &&
                            center > n1 && center > n2;
            d.row         = POS_W'(r - 1);
            d.column      = POS_W'(c - 1);
            d.last_of_run = (c != IMAGE_WIDTH - 1);
            expected_decisions.push_back(d);
            // last column: its own decision follows, always a border pixel
            if (c == IMAGE_WIDTH - 1)
            begin
                d.is_peak     = 1'b0;
                d.column      = POS_W'(c);
                d.last_of_run = 1'b1;
                expected_decisions.push_back(d);
            end
        end

        if (c + 1 >= IMAGE_WIDTH)
        begin
            pos_col = 0;
            pos_row = (r + 1 >= IMAGE_HEIGHT) ? 0 : r + 1;
        end
        else
            pos_col = c + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t got, want;
        int      i;
        if (!rst_n)
        begin
            for (i = 0; i < IMAGE_WIDTH; i++)
            begin
                line_above[i]     = '0;
                line_two_above[i] = '0;
                sector_row[i]     = SEC_VERT;
            end
            window      = '{default: '0};
            held_sector = SEC_VERT;
            pos_row     = 0;
            pos_col     = 0;
            expected_decisions.delete();
            outstanding = 0;
        end
        else
        begin
            // compare first: a decision never belongs to a pixel of this edge
            if (decisions.valid && decisions.ready)
            begin
                got.is_peak     = decisions.is_peak;
                got.row         = decisions.row;
                got.column      = decisions.column;
                got.last_of_run = decisions.last_of_run;
                decisions_seen++;
                if (got.is_peak === 1'b1)
                    peaks_seen++;
                if (expected_decisions.size() == 0)
                    report_mismatch($sformatf("unexpected decision row %0d col %0d",
                                              got.row, got.column));
                else
                begin
                    want = expected_decisions.pop_front();
                    if (got.row !== want.row)
                        report_mismatch($sformatf("row %0d, want %0d (col %0d)",
                                                  got.row, want.row, want.column));
                    if (got.column !== want.column)
                        report_mismatch($sformatf("column %0d, want %0d (row %0d)",
                                                  got.column, want.column, want.row));
                    if (got.is_peak !== want.is_peak)
                        report_mismatch($sformatf("is_peak %b, want %b at (%0d,%0d)",
                                                  got.is_peak, want.is_peak,
                                                  want.row, want.column));
                    if (got.last_of_run !== want.last_of_run)
                        report_mismatch($sformatf("last_of_run %b, want %b at (%0d,%0d)",
                                                  got.last_of_run, want.last_of_run,
                                                  want.row, want.column));
                end
            end
            if (pixels.valid && pixels.ready)
            begin
                pixels_seen++;
                predict_decisions(pixels.magnitude, pixels.gradient_x, pixels.gradient_y);
            end
            outstanding = expected_decisions.size();
        end
    end

endmodule

// ----- verif/gradient_non_maximum_suppression_tb.sv -----
// ----------------------------------------------------------------------------
// gradient_non_maximum_suppression_tb
// Drives a raster pixel stream into the suppression block with random stalls
// on both channels; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gradient_non_maximum_suppression_tb;
    import gnms_pkg::*;

    // First rows run under random stalls, a stretch in the middle runs at
    // full rate, and the remaining rows run stressed again.
    localparam int STRESS_HEAD_END = 3 * IMAGE_WIDTH;
    localparam int STREAM_END      = 5 * IMAGE_WIDTH;
    localparam int RUN_END         = 2000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int TIMEOUT_NS      = 20_000_000;

    // Threshold probes: gx = k * 1.0 in Q16, gy = k * threshold +- 1
    localparam int UNIT_Q16     = 65536;
    localparam int TAN_LOW_Q16  = 27145;
    localparam int TAN_HIGH_Q16 = 158217;

    localparam logic [MAG_IN_W-1:0]      MAG_MAX  = 24'hFFFFFF;
    localparam logic signed [GRAD_W-1:0] GRAD_MAX = 24'h7FFFFF;
    localparam logic signed [GRAD_W-1:0] GRAD_MIN = 24'h800000;

    logic clk;
    logic rst_n;

    // Idle control: full_rate switches off all gaps and stalls on both sides.
    bit          full_rate;
    int          burst_left;
    int unsigned pixels_sent;

    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned pixels_seen;
    int unsigned decisions_seen;
    int unsigned peaks_seen;

    gnms_pixel_if  pixel_bus ();
    gnms_result_if result_bus ();

    gradient_non_maximum_suppression u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel_in   (pixel_bus),
        .result_out (result_bus)
    );

    gnms_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .pixels         (pixel_bus),
        .decisions      (result_bus),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .pixels_seen    (pixels_seen),
        .decisions_seen (decisions_seen),
        .peaks_seen     (peaks_seen)
    );

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Single reset pulse at the start, released on a falling edge
    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Hard stop if the stream or the drain ever hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("TIMEOUT: %0d decision transactions still expected", outstanding);
        $display("Test completed with failures");
        $finish;
    end

    // Idle cycles ahead of the next pixel transaction. Mostly none, some short,
    // a few long; now and then a burst of back-to-back pixels.
    function automatic int sender_gap();
        int roll;
        if (burst_left != 0)
        begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(99);
        if (roll < 6)
        begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 60)
            return 0;
        if (roll < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    // Random pixel content. Plain uniform values cover every bit of every
    // field; the other mixes aim at sector edges, ties and the axis cases.
    task automatic pick_pixel(output logic [MAG_IN_W-1:0]      mag,
                              output logic signed [GRAD_W-1:0] gx,
                              output logic signed [GRAD_W-1:0] gy);
        int roll, k, gx_val, gy_val, slope;
        roll = $urandom_range(99);
        if (roll < 50)
        begin
            mag = MAG_IN_W'($urandom);
            gx  = GRAD_W'($urandom);
            gy  = GRAD_W'($urandom);
        end
        else if (roll < 65)
        begin
            // ratio exactly on, just below or just above a sector threshold
            k      = $urandom_range(1, 50);
            slope  = $urandom_range(1) ? TAN_HIGH_Q16 : TAN_LOW_Q16;
            gx_val = UNIT_Q16 * k;
            gy_val = slope * k + int'($urandom_range(2)) - 1;
            if ($urandom_range(1))
                gx_val = -gx_val;
            if ($urandom_range(1))
                gy_val = -gy_val;
            mag = MAG_IN_W'($urandom);
            gx  = gx_val[GRAD_W-1:0];
            gy  = gy_val[GRAD_W-1:0];
        end
        else if (roll < 80)
        begin
            // tiny magnitudes: many equal neighbors, so strictness matters
            mag    = MAG_IN_W'($urandom_range(3));
            gx_val = int'($urandom_range(8)) - 4;
            gy_val = int'($urandom_range(8)) - 4;
            gx     = gx_val[GRAD_W-1:0];
            gy     = gy_val[GRAD_W-1:0];
        end
        else if (roll < 90)
        begin
            // one component zero
            mag = MAG_IN_W'($urandom);
            gx  = GRAD_W'($urandom);
            gy  = GRAD_W'($urandom);
            if ($urandom_range(1))
                gx = '0;
            else
                gy = '0;
        end
        else
        begin
            // magnitude rails
            mag = $urandom_range(1) ? MAG_MAX : '0;
            gx  = GRAD_W'($urandom);
            gy  = GRAD_W'($urandom);
        end
    endtask

    // One pixel transaction: optional idle cycles, then hold valid until the
    // block takes it. Valid stays high across back-to-back transactions.
    task automatic send_pixel(input logic [MAG_IN_W-1:0]      mag,
                              input logic signed [GRAD_W-1:0] gx,
                              input logic signed [GRAD_W-1:0] gy);
        int gap;
        gap = full_rate ? 0 : sender_gap();
        repeat (gap)
        begin
            @(negedge clk);
            pixel_bus.valid <= 1'b0;
        end
        @(negedge clk);
        pixel_bus.valid      <= 1'b1;
        pixel_bus.magnitude  <= mag;
        pixel_bus.gradient_x <= gx;
        pixel_bus.gradient_y <= gy;
        do
            @(posedge clk);
        while (!pixel_bus.ready);
        pixels_sent++;
    endtask

    // Decision sink: alternating ready-high and ready-low stretches,
    // solid high while full_rate is set.
    initial
    begin
        int run_len;
        int roll;
        result_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (full_rate)
            begin
                @(negedge clk);
                result_bus.ready <= 1'b1;
            end
            else
            begin
                roll    = $urandom_range(99);
                run_len = (roll < 70) ? $urandom_range(1, 8) : $urandom_range(9, 40);
                repeat (run_len) @(negedge clk) result_bus.ready <= 1'b1;
                roll    = $urandom_range(99);
                run_len = (roll < 60) ? $urandom_range(1, 2) :
                          (roll < 90) ? $urandom_range(3, 6) : $urandom_range(10, 20);
                repeat (run_len) @(negedge clk) result_bus.ready <= 1'b0;
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        logic [MAG_IN_W-1:0]      mag;
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        full_rate            = 1'b0;
        burst_left           = 0;
        pixels_sent          = 0;
        pixel_bus.valid      = 1'b0;
        pixel_bus.magnitude  = '0;
        pixel_bus.gradient_x = '0;
        pixel_bus.gradient_y = '0;
        @(posedge rst_n);

        // Row 0 is random fill: it yields no decisions, but it
        // becomes the upper neighbor row of the directed cases below.
        while (pixels_sent < IMAGE_WIDTH)
        begin
            pick_pixel(mag, gx, gy);
            send_pixel(mag, gx, gy);
        end

        // Directed cases in row 1, where columns 1 through 254 are interior
        send_pixel('0,        '0,        '0);         // both zero -> vertical
        send_pixel(MAG_MAX,   '0,        GRAD_MAX);   // x zero -> horizontal
        send_pixel(24'd1,     '0,        GRAD_MIN);
        send_pixel(MAG_MAX,   GRAD_MAX,  '0);         // y zero -> vertical
        send_pixel(24'hFFFFFE, GRAD_MIN, '0);
        send_pixel(24'h800000, GRAD_MIN, GRAD_MIN);   // ratio +1, negative x
        send_pixel(24'h7FFFFF, GRAD_MAX, GRAD_MIN);   // ratio about -1
        send_pixel(MAG_MAX,   24'd65536, 24'd27145);  // on the low threshold
        send_pixel('0,        24'd65536, 24'd27146);  // just above it
        send_pixel(MAG_MAX,   24'd65536, -24'sd27145);
        send_pixel(24'd1,     24'd65536, -24'sd27144);
        send_pixel(MAG_MAX,   24'd65536, 24'd158217); // on the high threshold
        send_pixel('0,        24'd65536, 24'd158218);
        send_pixel(MAG_MAX,   24'd65536, -24'sd158217);
        send_pixel(24'd2,     24'd65536, -24'sd158216);
        send_pixel(MAG_MAX,   -24'sd65536, 24'd27145);
        send_pixel('0,        -24'sd65536, -24'sd158217);
        send_pixel(24'd5,     24'd1,     24'd1);
        send_pixel(24'd5,     24'd1,     -24'sd1);    // equal magnitudes
        send_pixel(24'd5,     -24'sd1,   '0);

        // Random body; a middle stretch streams at full rate on both sides
        while (pixels_sent < RUN_END)
        begin
            full_rate = (pixels_sent >= STRESS_HEAD_END) && (pixels_sent < STREAM_END);
            pick_pixel(mag, gx, gy);
            send_pixel(mag, gx, gy);
        end
        @(negedge clk);
        pixel_bus.valid <= 1'b0;

        // Drain: sink always ready, wait for every decision, then wait on to catch anything extra
        full_rate = 1'b1;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d pixel transactions over %0d image rows, %0d decisions, %0d peaks",
                 pixels_seen, pixels_seen / IMAGE_WIDTH, decisions_seen, peaks_seen);
        $display("Included sector thresholds, zero gradients, ties, borders and random stalls");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
